>>> rtl/tts_pkg.sv
`default_nettype none
package tts_pkg;

  // accumulator width default and queue depths (depths are powers of two)
  localparam int VALUE_BITS_DEF = 32;
  localparam int CLS_DEPTH      = 2;
  localparam int OUT_DEPTH      = 4;

  // result kinds
  localparam logic [2:0] KIND_IDENT_CHAR  = 3'd0;
  localparam logic [2:0] KIND_STRING_CHAR = 3'd1;
  localparam logic [2:0] KIND_IDENT_END   = 3'd2;
  localparam logic [2:0] KIND_STRING_END  = 3'd3;
  localparam logic [2:0] KIND_NUMBER      = 3'd4;
  localparam logic [2:0] KIND_PUNCT       = 3'd5;
  localparam logic [2:0] KIND_ERROR       = 3'd6;
  localparam logic [2:0] KIND_END         = 3'd7;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OCT_DIGIT = 2'd1;
  localparam logic [1:0] ERR_EOI_TOKEN = 2'd2;

  // characters
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  text_char;
    logic [31:0] number_value;
    logic [31:0] line_number;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  // classified character handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] up_ch;
    logic       eoi;
    logic       is_space;
    logic       is_digit;
    logic       is_oct_bad;
    logic       is_ident_start;
    logic       is_ident;
    logic       is_hash;
    logic       is_quote;
    logic       is_bslash;
    logic       is_nl;
    logic       is_x;
    logic       hex_ok;
    logic [3:0] hex_val;
  } cls_t;

endpackage
`default_nettype wire

>>> rtl/tts_fifo.sv
`default_nettype none
module tts_fifo
  import tts_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push_a,
  input  wire logic [W-1:0]               data_a,
  input  wire logic                       push_b,
  input  wire logic [W-1:0]               data_b,
  input  wire logic                       pop,
  output      logic [W-1:0]               head,
  output      logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  // second push only goes with a first one
  always_comb begin
    cnt_nxt = cnt_r + (AW+1)'(push_a) + (AW+1)'(push_a & push_b) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        rp_r <= rp_r + AW'(1);
      end
      if (push_a && push_b) begin
        wp_r <= wp_r + AW'(2);
      end else if (push_a) begin
        wp_r <= wp_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wp_r] <= data_a;
    end
    if (push_a && push_b) begin
      mem_r[wp_r + AW'(1)] <= data_b;
    end
  end

  assign head  = mem_r[rp_r];
  assign count = cnt_r;

endmodule
`default_nettype wire

>>> rtl/tts_front.sv
`default_nettype none
module tts_front
  import tts_pkg::*;
(
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output      logic     in_ready,
  output      logic     push,
  output      cls_t     cls
);

  logic [7:0] c;
  logic       lower, upper, digit, hex_lo, hex_up;

  assign c = in_data.char_code;

  always_comb begin
    digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    lower  = (c >= 8'h61) && (c <= 8'h7A);
    upper  = (c >= 8'h41) && (c <= 8'h5A);
    hex_lo = (c >= 8'h61) && (c <= 8'h66);
    hex_up = (c >= 8'h41) && (c <= 8'h46);

    cls.ch             = c;
    cls.up_ch          = lower ? (c - CASE_DIFF) : c;
    cls.eoi            = in_data.end_of_input;
    cls.is_space       = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    cls.is_digit       = digit;
    cls.is_oct_bad     = digit && (c > CH_SEVEN);
    cls.is_ident_start = lower || upper || (c == CH_USCORE);
    cls.is_ident       = lower || upper || digit || (c == CH_USCORE) || (c == CH_SLASH);
    cls.is_hash        = (c == CH_HASH);
    cls.is_quote       = (c == CH_QUOTE);
    cls.is_bslash      = (c == CH_BSLASH);
    cls.is_nl          = (c == CH_LF);
    cls.is_x           = (c == CH_LOW_X) || (c == CH_UP_X);
    cls.hex_ok         = digit || hex_lo || hex_up;
    // letters a-f / A-F: low nibble 1..6 maps to 10..15
    cls.hex_val        = digit ? c[3:0] : (c[3:0] + 4'd9);
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule
`default_nettype wire

>>> rtl/tts_back.sv
`default_nettype none
module tts_back
  import tts_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cls_valid,
  input  wire cls_t      cls,
  input  wire logic      room,
  output      logic      pop,
  output      logic      push_a,
  output      out_item_t res_a,
  output      logic      push_b,
  output      out_item_t res_b
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_ZERO    = 4'd2;
  localparam logic [3:0] M_DEC     = 4'd3;
  localparam logic [3:0] M_OCT     = 4'd4;
  localparam logic [3:0] M_HEX     = 4'd5;
  localparam logic [3:0] M_IDENT   = 4'd6;
  localparam logic [3:0] M_STRING  = 4'd7;
  localparam logic [3:0] M_ESCAPE  = 4'd8;

  logic [3:0]            mode_r, mode_nxt, idle_mode;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt, idle_acc, hv_ext;
  logic [31:0]           line_r, line_nxt;
  logic                  halted_r, halted_nxt;
  logic                  e0, e1, idle_emit;
  out_item_t             r0, r1, idle_res;

  function automatic out_item_t mk(input logic [2:0] kind, input logic [7:0] ch,
                                   input logic [31:0] val, input logic [1:0] err,
                                   input logic [31:0] line);
    out_item_t r;
    r.kind         = kind;
    r.text_char    = ch;
    r.number_value = val;
    r.line_number  = line;
    r.error_code   = err;
    r.last_of_run  = 1'b1;
    return r;
  endfunction

  assign pop    = cls_valid && room;
  assign hv_ext = VALUE_BITS'(cls.hex_val);

  // what a character does when no token is open
  always_comb begin
    idle_emit = 1'b0;
    idle_res  = mk(KIND_PUNCT, cls.ch, 32'd0, ERR_NONE, line_r);
    idle_mode = M_IDLE;
    idle_acc  = acc_r;
    if (cls.eoi) begin
      idle_emit = 1'b1;
      idle_res  = mk(KIND_END, 8'd0, 32'd0, ERR_NONE, line_r);
    end else if (cls.is_space) begin
      idle_mode = M_IDLE;
    end else if (cls.is_hash) begin
      idle_mode = M_COMMENT;
    end else if (cls.ch == CH_ZERO) begin
      idle_acc  = '0;
      idle_mode = M_ZERO;
    end else if (cls.is_digit) begin
      idle_acc  = hv_ext;
      idle_mode = M_DEC;
    end else if (cls.is_ident_start) begin
      idle_mode = M_IDENT;
      idle_emit = 1'b1;
      idle_res  = mk(KIND_IDENT_CHAR, cls.up_ch, 32'd0, ERR_NONE, line_r);
    end else if (cls.is_quote) begin
      idle_mode = M_STRING;
    end else begin
      idle_emit = 1'b1;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    line_nxt   = line_r;
    halted_nxt = halted_r;
    e0         = 1'b0;
    e1         = 1'b0;
    r0         = mk(KIND_END, 8'd0, 32'd0, ERR_NONE, line_r);
    r1         = r0;
    if (pop && !halted_r) begin
      case (mode_r)
        M_COMMENT: begin
          if (cls.eoi) begin
            mode_nxt = M_IDLE;
            e0       = 1'b1;
          end else if (cls.is_nl) begin
            mode_nxt = M_IDLE;
          end
        end
        M_ZERO: begin
          if (cls.eoi) begin
            mode_nxt = M_IDLE;
            e0       = 1'b1;
            r0       = mk(KIND_NUMBER, 8'd0, 32'd0, ERR_NONE, line_r);
            e1       = 1'b1;
          end else if (cls.is_x) begin
            acc_nxt  = '0;
            mode_nxt = M_HEX;
          end else if (cls.is_oct_bad) begin
            halted_nxt = 1'b1;
            mode_nxt   = M_IDLE;
            e0         = 1'b1;
            r0         = mk(KIND_ERROR, 8'd0, 32'd0, ERR_OCT_DIGIT, line_r);
          end else if (cls.is_digit) begin
            acc_nxt  = hv_ext;
            mode_nxt = M_OCT;
          end else begin
            e0       = 1'b1;
            r0       = mk(KIND_NUMBER, 8'd0, 32'd0, ERR_NONE, line_r);
            e1       = idle_emit;
            r1       = idle_res;
            mode_nxt = idle_mode;
            acc_nxt  = idle_acc;
          end
        end
        M_DEC, M_OCT, M_HEX: begin
          if (cls.eoi) begin
            halted_nxt = 1'b1;
            mode_nxt   = M_IDLE;
            e0         = 1'b1;
            r0         = mk(KIND_ERROR, 8'd0, 32'd0, ERR_EOI_TOKEN, line_r);
          end else if ((mode_r == M_DEC) && cls.is_digit) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + hv_ext;
          end else if ((mode_r == M_OCT) && cls.is_digit) begin
            if (cls.is_oct_bad) begin
              halted_nxt = 1'b1;
              mode_nxt   = M_IDLE;
              e0         = 1'b1;
              r0         = mk(KIND_ERROR, 8'd0, 32'd0, ERR_OCT_DIGIT, line_r);
            end else begin
              acc_nxt = (acc_r << 3) + hv_ext;
            end
          end else if ((mode_r == M_HEX) && cls.hex_ok) begin
            acc_nxt = (acc_r << 4) + hv_ext;
          end else begin
            e0       = 1'b1;
            r0       = mk(KIND_NUMBER, 8'd0, 32'(acc_r), ERR_NONE, line_r);
            e1       = idle_emit;
            r1       = idle_res;
            mode_nxt = idle_mode;
            acc_nxt  = idle_acc;
          end
        end
        M_IDENT: begin
          if (cls.eoi) begin
            halted_nxt = 1'b1;
            mode_nxt   = M_IDLE;
            e0         = 1'b1;
            r0         = mk(KIND_ERROR, 8'd0, 32'd0, ERR_EOI_TOKEN, line_r);
          end else if (cls.is_ident) begin
            e0 = 1'b1;
            r0 = mk(KIND_IDENT_CHAR, cls.up_ch, 32'd0, ERR_NONE, line_r);
          end else begin
            e0       = 1'b1;
            r0       = mk(KIND_IDENT_END, 8'd0, 32'd0, ERR_NONE, line_r);
            e1       = idle_emit;
            r1       = idle_res;
            mode_nxt = idle_mode;
            acc_nxt  = idle_acc;
          end
        end
        M_STRING: begin
          if (cls.eoi) begin
            halted_nxt = 1'b1;
            mode_nxt   = M_IDLE;
            e0         = 1'b1;
            r0         = mk(KIND_ERROR, 8'd0, 32'd0, ERR_EOI_TOKEN, line_r);
          end else if (cls.is_quote) begin
            mode_nxt = M_IDLE;
            e0       = 1'b1;
            r0       = mk(KIND_STRING_END, 8'd0, 32'd0, ERR_NONE, line_r);
          end else if (cls.is_bslash) begin
            mode_nxt = M_ESCAPE;
          end else begin
            e0 = 1'b1;
            r0 = mk(KIND_STRING_CHAR, cls.ch, 32'd0, ERR_NONE, line_r);
          end
        end
        M_ESCAPE: begin
          if (cls.eoi) begin
            halted_nxt = 1'b1;
            mode_nxt   = M_IDLE;
            e0         = 1'b1;
            r0         = mk(KIND_ERROR, 8'd0, 32'd0, ERR_EOI_TOKEN, line_r);
          end else begin
            mode_nxt = M_STRING;
            e0       = 1'b1;
            r0       = mk(KIND_STRING_CHAR, cls.ch, 32'd0, ERR_NONE, line_r);
          end
        end
        default: begin
          mode_nxt = idle_mode;
          acc_nxt  = idle_acc;
          e0       = idle_emit;
          r0       = idle_res;
        end
      endcase
      if (!halted_nxt && !cls.eoi && cls.is_nl) begin
        line_nxt = line_r + 32'd1;
      end
    end
    r0.last_of_run = !e1;
  end

  assign push_a = e0;
  assign res_a  = r0;
  assign push_b = e1;
  assign res_b  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      acc_r    <= '0;
      line_r   <= 32'd1;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      line_r   <= line_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/text_token_scanner.sv
`default_nettype none
// channel  | ports                          | direction | carries
// ---------+--------------------------------+-----------+---------------------------------
// input    | in_valid, in_ready, in_data    | in        | one character or end of input
// result   | out_valid, out_ready, out_data | out       | one token result
//
// an accepted character is classified and queued in the same cycle; the scan engine
// takes one queued character a cycle, so one character per cycle is sustained while
// each character gives at most one result and the result side keeps up
// a character ending a number or identifier can give two results, both queued at once; the result
// queue then drains them in turn, which sets the rate on such input
// rst_n (synchronous, active low) empties both queues and sets the scanner to idle,
// line 1, accumulator zero, not halted
// a stalled result side stops the engine once under two result slots are free, then
// fills the character queue and drops in_ready; in_ready never looks at out_ready
module text_token_scanner
  import tts_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  localparam int CLS_W = $bits(cls_t);
  localparam int OUT_W = $bits(out_item_t);
  localparam int CAW   = $clog2(CLS_DEPTH);
  localparam int OAW   = $clog2(OUT_DEPTH);

  // front to queue
  logic          cls_push;
  cls_t          cls_in;
  logic [CLS_W-1:0] cls_head;
  logic [CAW:0]  cls_cnt;

  // queue to back
  logic          cls_pop;
  logic          room;

  // back to result queue
  logic          push_a, push_b;
  out_item_t     res_a, res_b;
  logic [OUT_W-1:0] out_head;
  logic [OAW:0]  out_cnt;
  logic          out_pop;

  // front: classify and request a slot in the character queue
  tts_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (cls_cnt == (CAW+1)'(CLS_DEPTH)),
    .in_ready (in_ready),
    .push     (cls_push),
    .cls      (cls_in)
  );

  // short queue of classified characters
  tts_fifo #(
    .W     (CLS_W),
    .DEPTH (CLS_DEPTH)
  ) u_cls_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_a (cls_push),
    .data_a (cls_in),
    .push_b (1'b0),
    .data_b ('0),
    .pop    (cls_pop),
    .head   (cls_head),
    .count  (cls_cnt)
  );

  // engine only runs when two result slots are free
  assign room = out_cnt <= (OAW+1)'(OUT_DEPTH - 2);

  tts_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cls_cnt != '0),
    .cls       (cls_t'(cls_head)),
    .room      (room),
    .pop       (cls_pop),
    .push_a    (push_a),
    .res_a     (res_a),
    .push_b    (push_b),
    .res_b     (res_b)
  );

  // result queue, head drives the output
  tts_fifo #(
    .W     (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_a (push_a),
    .data_a (res_a),
    .push_b (push_b),
    .data_b (res_b),
    .pop    (out_pop),
    .head   (out_head),
    .count  (out_cnt)
  );

  assign out_valid = out_cnt != '0;
  assign out_pop   = out_valid && out_ready;
  assign out_data  = out_item_t'(out_head);

`ifndef SYNTHESIS
  // result queue never overfills
  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt <= (OAW+1)'(OUT_DEPTH))
    else $error("result queue overflow");

  // a second result only with a first one
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    push_b |-> push_a)
    else $error("second result without first");

  // an accepted request is held in the character queue next cycle
  a_cls_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (cls_cnt != '0))
    else $error("accepted character lost");

  // engine only consumes when room for two results
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    cls_pop |-> (out_cnt <= (OAW+1)'(OUT_DEPTH - 2)))
    else $error("engine popped without room");
`endif

endmodule
`default_nettype wire
